@@ rtl/mmga_pkg.sv @@
// Shared constants, command codes, handshake structs and the saturating adder.
package mmga_pkg;

    localparam int GROUPS    = 16;
    localparam int WORDS     = 64;
    localparam int LANES     = 16;
    localparam int MASK_BITS = 16;

    localparam int ACC_W  = 48;
    localparam int VAL_W  = 32;
    localparam int GRP_W  = 4;
    localparam int WORD_W = 6;
    localparam int LANE_W = 4;
    localparam int CMD_W  = 2;
    localparam int INTV_W = 10;

    localparam int ROWS   = GROUPS * WORDS;
    localparam int ROW_AW = $clog2(ROWS);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;
    localparam int GCNT_W    = 5;
    localparam int WCNT_W    = 7;

    localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT  = 2'd2;

    localparam logic [GCNT_W-1:0] GCNT_RESET = GCNT_W'(1);
    localparam logic [WCNT_W-1:0] WCNT_RESET = WCNT_W'(64);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic [LANES-1:0][ACC_W-1:0] t_row;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              take;
        logic              commit;
        logic              emit;
        logic              sweep;
        logic [ROW_AW-1:0] sweep_addr;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic has_result;
        logic out_free;
    } t_dp_stat;

    // Adds a delta one bit wider than the accumulator and clamps to 48-bit signed.
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [ACC_W:0]   delta);
        logic [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + delta;
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

@@ rtl/mmga_ctrl.sv @@
// Controller state machine: reset clearing sweep, item intake and execution.
module mmga_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mmga_pkg::t_dp_stat   i_stat,
    output mmga_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [mmga_pkg::ROW_AW-1:0]   r_sweep, n_sweep;
    logic                          accept;

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state           = r_state;
        n_sweep           = r_sweep;
        o_in_ready        = 1'b0;
        o_cmd.take        = 1'b0;
        o_cmd.commit      = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.sweep       = 1'b0;
        o_cmd.sweep_addr  = r_sweep;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                n_sweep     = r_sweep + 1'b1;
                if (r_sweep == mmga_pkg::ROW_AW'(mmga_pkg::ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = accept;
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.has_result) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_EXEC)
        else $error("accepted beat did not move to execution");

    a_no_intake_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep |-> !o_in_ready && !o_cmd.emit && !o_cmd.commit)
        else $error("intake or execution during the clearing sweep");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.has_result && i_stat.out_free)
        else $error("result loaded into a full output register");

    a_commit_emit_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit && o_cmd.emit))
        else $error("commit and emit in the same cycle");

endmodule

@@ rtl/mmga_dp.sv @@
// Datapath: configuration registers, accumulator memory, lane adders, output register.
module mmga_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mmga_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mmga_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic [mmga_pkg::CMD_W-1:0]            i_cmd,
    input  logic [mmga_pkg::GRP_W-1:0]            i_group,
    input  logic [mmga_pkg::WORD_W-1:0]           i_word_index,
    input  logic [mmga_pkg::MASK_BITS-1:0]        i_mask,
    input  logic signed [mmga_pkg::VAL_W-1:0]     i_value,
    input  logic [mmga_pkg::LANE_W-1:0]           i_lane,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [mmga_pkg::ACC_W-1:0]     o_total,
    output logic [mmga_pkg::GRP_W-1:0]            o_out_group,
    output logic [mmga_pkg::INTV_W-1:0]           o_intervention,
    output logic                                  o_bad_index,
    input  mmga_pkg::t_dp_cmd                     i_cmd_ctl,
    output mmga_pkg::t_dp_stat                    o_stat
);

    // Configuration registers.
    logic                          r_agg_mode;
    logic [mmga_pkg::GCNT_W-1:0]   r_group_count;
    logic [mmga_pkg::WCNT_W-1:0]   r_word_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agg_mode    <= 1'b0;
            r_group_count <= mmga_pkg::GCNT_RESET;
            r_word_count  <= mmga_pkg::WCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mmga_pkg::CFG_AGG_MODE:    r_agg_mode    <= i_cfg_data[0];
                mmga_pkg::CFG_GROUP_COUNT: r_group_count <= i_cfg_data[mmga_pkg::GCNT_W-1:0];
                mmga_pkg::CFG_WORD_COUNT:  r_word_count  <= i_cfg_data[mmga_pkg::WCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Item registers, captured on intake.
    logic [mmga_pkg::CMD_W-1:0]        r_cmd;
    logic [mmga_pkg::GRP_W-1:0]        r_grp;
    logic [mmga_pkg::WORD_W-1:0]       r_word;
    logic [mmga_pkg::MASK_BITS-1:0]    r_mask;
    logic signed [mmga_pkg::VAL_W-1:0] r_val;
    logic [mmga_pkg::LANE_W-1:0]       r_lane;
    logic                              r_ok;
    logic [mmga_pkg::ROW_AW-1:0]       r_addr;

    logic                              in_ok;
    logic [mmga_pkg::ROW_AW-1:0]       in_addr;

    assign in_ok = (mmga_pkg::GCNT_W'(i_group) < r_group_count)
                && (32'(i_group) < 32'(mmga_pkg::GROUPS))
                && (mmga_pkg::WCNT_W'(i_word_index) < r_word_count)
                && (32'(i_word_index) < 32'(mmga_pkg::WORDS));

    assign in_addr = mmga_pkg::ROW_AW'(i_group) * mmga_pkg::ROW_AW'(mmga_pkg::WORDS)
                   + mmga_pkg::ROW_AW'(i_word_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.take) begin
            r_cmd  <= i_cmd;
            r_grp  <= i_group;
            r_word <= i_word_index;
            r_mask <= i_mask;
            r_val  <= i_value;
            r_lane <= i_lane;
            r_ok   <= in_ok;
            r_addr <= in_addr;
        end
    end

    // Accumulator memory: one row holds all lanes of one (group, word).
    mmga_pkg::t_row r_mem [mmga_pkg::ROWS];
    mmga_pkg::t_row r_rd;
    mmga_pkg::t_row wr_row;
    logic                        wr_en;
    logic [mmga_pkg::ROW_AW-1:0] wr_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.take) begin
            r_rd <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
    end

    logic                        is_write_cmd;
    logic [mmga_pkg::ACC_W:0]    delta;
    mmga_pkg::t_row              acc_row;

    assign is_write_cmd = (r_cmd == mmga_pkg::CMD_ACC) || (r_cmd == mmga_pkg::CMD_CLEAR);
    assign delta = r_agg_mode ? (mmga_pkg::ACC_W + 1)'(r_val) : (mmga_pkg::ACC_W + 1)'(1);

    always_comb begin
        for (int k = 0; k < mmga_pkg::LANES; k++) begin
            acc_row[k] = r_rd[k];
            if (k < mmga_pkg::MASK_BITS) begin
                if (r_mask[k]) begin
                    acc_row[k] = mmga_pkg::sat_add(r_rd[k], delta);
                end
            end
        end
    end

    always_comb begin
        wr_en   = i_cmd_ctl.sweep || (i_cmd_ctl.commit && r_ok && is_write_cmd);
        wr_addr = i_cmd_ctl.sweep ? i_cmd_ctl.sweep_addr : r_addr;
        if (i_cmd_ctl.sweep || r_cmd == mmga_pkg::CMD_CLEAR) begin
            wr_row = '0;
        end else begin
            wr_row = acc_row;
        end
    end

    // Result formation.
    logic                        lane_ok;
    logic                        rd_ok;
    logic [mmga_pkg::INTV_W-1:0] base_intv;

    assign lane_ok   = 32'(r_lane) < 32'(mmga_pkg::LANES);
    assign rd_ok     = r_ok && lane_ok;
    assign base_intv = mmga_pkg::INTV_W'(r_word) * mmga_pkg::INTV_W'(mmga_pkg::MASK_BITS);

    assign o_stat.has_result = (r_cmd == mmga_pkg::CMD_READ) || (is_write_cmd && !r_ok);
    assign o_stat.out_free   = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd_ctl.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.emit) begin
            o_out_group <= r_grp;
            if (r_cmd == mmga_pkg::CMD_READ) begin
                o_intervention <= base_intv + mmga_pkg::INTV_W'(r_lane);
                o_bad_index    <= !rd_ok;
                o_total        <= rd_ok ? r_rd[r_lane] : '0;
            end else begin
                o_intervention <= base_intv;
                o_bad_index    <= 1'b1;
                o_total        <= '0;
            end
        end
    end

endmodule

@@ rtl/masked_multiworld_group_aggregate.sv @@
// Top level of the masked multi-world group aggregator.
//
// This block keeps one 48-bit signed accumulator for every (group, mask word,
// lane) triple, 16 groups by 64 words by 16 lanes, where each lane stands for
// one what-if intervention numbered word_index*16+lane. An accumulate beat adds
// 1 (count mode) or its Q16.16 value (sum mode) to every lane whose mask bit is
// set, saturating at the 48-bit signed limits. A read beat returns one
// accumulator; a clear beat zeroes the 16 lanes of one (group, word). A beat
// whose group or word lies beyond the configured counts changes nothing and
// returns a result with bad_index set and a zero total; command three is
// dropped silently. The accumulators live in a single-port-style memory of
// 1024 rows of 16 lanes, so each beat costs one row read and at most one row
// write: an item passes through intake with the row read, then the lane adders
// and the write-back or result load, and the input is ready again right after.
// A result stays in the output register until taken; the next beat is accepted
// meanwhile and only stalls in execution if it too produces a result while the
// register is still full. After reset the block clears the memory one row per
// cycle before it raises input ready; configuration writes are accepted
// throughout. Write the configuration registers only while the block is idle.
module masked_multiworld_group_aggregate (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mmga_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mmga_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [mmga_pkg::CMD_W-1:0]            i_cmd,
    input  logic [mmga_pkg::GRP_W-1:0]            i_group,
    input  logic [mmga_pkg::WORD_W-1:0]           i_word_index,
    input  logic [mmga_pkg::MASK_BITS-1:0]        i_mask,
    input  logic signed [mmga_pkg::VAL_W-1:0]     i_value,
    input  logic [mmga_pkg::LANE_W-1:0]           i_lane,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mmga_pkg::ACC_W-1:0]     o_total,
    output logic [mmga_pkg::GRP_W-1:0]            o_out_group,
    output logic [mmga_pkg::INTV_W-1:0]           o_intervention,
    output logic                                  o_bad_index
);

    // The controller sequences the sweep and each beat; the datapath owns the data
    // storage and lane arithmetic and reports whether the held beat needs a result.
    mmga_pkg::t_dp_cmd  dp_cmd;
    mmga_pkg::t_dp_stat dp_stat;

    mmga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mmga_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_group        (i_group),
        .i_word_index   (i_word_index),
        .i_mask         (i_mask),
        .i_value        (i_value),
        .i_lane         (i_lane),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_total        (o_total),
        .o_out_group    (o_out_group),
        .o_intervention (o_intervention),
        .o_bad_index    (o_bad_index),
        .i_cmd_ctl      (dp_cmd),
        .o_stat         (dp_stat)
    );

endmodule
